@@ hdl/rvpc_pkg.sv @@
// Shared types, constants and helpers for the ROI point centroid block.
`timescale 1ns / 1ps
`default_nettype none

package rvpc_pkg;

  localparam int AXES          = 3;
  localparam int FIX_W         = 32;
  localparam int SUM_W         = 54;
  localparam int TALLY_W       = 23;
  localparam int REM_W         = TALLY_W;
  localparam int DIV_CNT_W     = $clog2(SUM_W + 1);
  localparam int QUEUE_DEPTH   = 4;
  localparam int CFG_ADDR_W    = 5;
  localparam int CFG_DATA_W    = 32;
  localparam int WIDTH_REG_W   = 12;
  localparam int FIRST_REG_W   = 11;
  localparam int END_REG_W     = 12;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;
  localparam int DEF_FRAC_BITS  = 16;

  localparam logic [WIDTH_REG_W-1:0] IMAGE_WIDTH_RESET = WIDTH_REG_W'(640);
  localparam logic [TALLY_W-1:0]     TALLY_MAX         = '1;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [2:0] REG_BOX_COL_FIRST = 3'd1;
  localparam logic [2:0] REG_BOX_COL_END   = 3'd2;
  localparam logic [2:0] REG_BOX_ROW_FIRST = 3'd3;
  localparam logic [2:0] REG_BOX_ROW_END   = 3'd4;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV,
    ST_DONE
  } back_state_t;

  // one classified point on its way from front to back
  typedef struct packed {
    logic [AXES-1:0][FIX_W-1:0] coord;
    logic                       keep;
    logic                       last;
  } pt_t;

  // exponent all ones: NaN or infinity
  function automatic logic is_finite(input logic [31:0] bits);
    return bits[30:23] != 8'hFF;
  endfunction

  // float32 to signed fixed point, truncated toward zero, saturated
  function automatic logic [FIX_W-1:0] to_fixed(input logic [31:0] bits, input int frac);
    int                 sh;
    logic [FIX_W-1:0]   mag;
    logic [FIX_W-1:0]   res;
    sh  = int'(bits[30:23]) - 150 + frac;
    mag = {8'd0, 1'b1, bits[22:0]};
    if (bits[30:23] == 8'd0) begin
      res = '0;
    end else if (sh >= 8) begin
      res = bits[31] ? {1'b1, {(FIX_W-1){1'b0}}} : {1'b0, {(FIX_W-1){1'b1}}};
    end else begin
      if (sh >= 0) begin
        mag = mag << sh;
      end else if (sh <= -25) begin
        mag = '0;
      end else begin
        mag = mag >> (-sh);
      end
      res = bits[31] ? (~mag + 1'b1) : mag;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ hdl/rvpc_queue.sv @@
// Short register queue of classified points between front and back.
`timescale 1ns / 1ps
`default_nettype none

module rvpc_queue
  import rvpc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire pt_t  push_data,
  output logic      full,
  input  wire logic pop,
  output pt_t       pop_data,
  output logic      empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pt_t              slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = count_r == CNT_W'(DEPTH);
  assign empty    = count_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ hdl/rvpc_front.sv @@
// Front end: raster position tracking, box and finiteness test, float to fixed.
`timescale 1ns / 1ps
`default_nettype none

module rvpc_front
  import rvpc_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_push,
  output logic                        in_full,
  input  wire logic [31:0]            in_coord_x_bits,
  input  wire logic [31:0]            in_coord_y_bits,
  input  wire logic [31:0]            in_coord_z_bits,
  input  wire logic                   in_frame_end,
  input  wire logic [WIDTH_REG_W-1:0] image_width,
  input  wire logic [FIRST_REG_W-1:0] box_col_first,
  input  wire logic [END_REG_W-1:0]   box_col_end,
  input  wire logic [FIRST_REG_W-1:0] box_row_first,
  input  wire logic [END_REG_W-1:0]   box_row_end,
  output logic                        q_push,
  output pt_t                         q_data,
  input  wire logic                   q_full
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [31:0]      width_eff;
  logic             accept, in_box, finite;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  always_comb begin
    if (image_width == '0) begin
      width_eff = 32'd1;
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      width_eff = 32'(MAX_WIDTH);
    end else begin
      width_eff = 32'(image_width);
    end
  end

  assign in_box = (32'(col_r) >= 32'(box_col_first)) && (32'(col_r) < 32'(box_col_end)) &&
                  (32'(row_r) >= 32'(box_row_first)) && (32'(row_r) < 32'(box_row_end));
  assign finite = is_finite(in_coord_x_bits) && is_finite(in_coord_y_bits) &&
                  is_finite(in_coord_z_bits);

  always_comb begin
    q_data.coord[0] = to_fixed(in_coord_x_bits, FRAC_BITS);
    q_data.coord[1] = to_fixed(in_coord_y_bits, FRAC_BITS);
    q_data.coord[2] = to_fixed(in_coord_z_bits, FRAC_BITS);
    q_data.keep     = in_box && finite;
    q_data.last     = in_frame_end;
  end

  // dropped points that close no frame never enter the queue
  assign q_push = accept && (q_data.keep || in_frame_end);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (in_frame_end) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (32'(col_r) + 32'd1 >= width_eff) begin
        col_nxt = '0;
        row_nxt = (row_r == ROW_W'(MAX_HEIGHT - 1)) ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/rvpc_div.sv @@
// Shared-count restoring divider, one quotient bit per cycle on all three axes.
`timescale 1ns / 1ps
`default_nettype none

module rvpc_div
  import rvpc_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [AXES-1:0][SUM_W-1:0]  dividend,
  input  wire logic [TALLY_W-1:0]          divisor,
  output logic                             busy,
  output logic [AXES-1:0][SUM_W-1:0]       quot,
  output logic [AXES-1:0]                  neg
);

  logic                     busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [TALLY_W-1:0]       dvs_r;
  logic [AXES-1:0][SUM_W-1:0] acc_r, acc_nxt;
  logic [AXES-1:0][REM_W-1:0] rem_r, rem_nxt;
  logic [AXES-1:0]          neg_r;
  logic [REM_W:0]           trial [AXES];

  assign busy = busy_r;
  assign quot = acc_r;
  assign neg  = neg_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    for (int l = 0; l < AXES; l++) begin
      trial[l] = {rem_r[l], acc_r[l][SUM_W-1]};
    end
    if (busy_r) begin
      for (int l = 0; l < AXES; l++) begin
        if (trial[l] >= {1'b0, dvs_r}) begin
          rem_nxt[l] = REM_W'(trial[l] - {1'b0, dvs_r});
          acc_nxt[l] = {acc_r[l][SUM_W-2:0], 1'b1};
        end else begin
          rem_nxt[l] = REM_W'(trial[l]);
          acc_nxt[l] = {acc_r[l][SUM_W-2:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_CNT_W'(SUM_W);
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs_r <= divisor;
      for (int l = 0; l < AXES; l++) begin
        neg_r[l] <= dividend[l][SUM_W-1];
        acc_r[l] <= dividend[l][SUM_W-1] ? (~dividend[l] + 1'b1) : dividend[l];
        rem_r[l] <= '0;
      end
    end else begin
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/rvpc_back.sv @@
// Back end: saturating sums and tally, frame close with mean division, result register.
`timescale 1ns / 1ps
`default_nettype none

module rvpc_back
  import rvpc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_empty,
  input  wire pt_t                 q_data,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_pop,
  output logic signed [FIX_W-1:0]  out_mean_x,
  output logic signed [FIX_W-1:0]  out_mean_y,
  output logic signed [FIX_W-1:0]  out_mean_z,
  output logic [TALLY_W-1:0]       out_kept_count,
  output logic                     out_box_empty
);

  back_state_t                state_r, state_nxt;
  logic [AXES-1:0][SUM_W-1:0] sum_r, sum_nxt, sum_upd, acc_sum;
  logic [TALLY_W-1:0]         tally_r, tally_nxt, acc_tally;
  logic [TALLY_W-1:0]         cnt_r, cnt_nxt;
  logic                       acc_take;
  logic                       div_start, div_busy;
  logic [AXES-1:0][SUM_W-1:0] div_quot;
  logic [AXES-1:0]            div_neg;
  logic                       out_valid_r, slot_free, load_out;
  logic [AXES-1:0][FIX_W-1:0] mean_r, mean_nxt;
  logic [TALLY_W-1:0]         kept_r;
  logic                       empty_r;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                               input logic [FIX_W-1:0] v);
    logic [SUM_W:0] r;
    r = {s[SUM_W-1], s} + (SUM_W+1)'($signed(v));
    if (r[SUM_W] != r[SUM_W-1]) begin
      return r[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return r[SUM_W-1:0];
  endfunction

  function automatic logic [FIX_W-1:0] clamp_mean(input logic [SUM_W-1:0] q, input logic n);
    logic [SUM_W-1:0] lim;
    lim = SUM_W'({1'b1, {(FIX_W-1){1'b0}}});
    if (n) begin
      return (q > lim) ? {1'b1, {(FIX_W-1){1'b0}}} : (~q[FIX_W-1:0] + 1'b1);
    end
    return (q >= lim) ? {1'b0, {(FIX_W-1){1'b1}}} : q[FIX_W-1:0];
  endfunction

  assign acc_take  = q_data.keep && (tally_r != TALLY_MAX);
  assign acc_tally = acc_take ? tally_r + 1'b1 : tally_r;

  always_comb begin
    for (int l = 0; l < AXES; l++) begin
      sum_upd[l]  = sat_add(sum_r[l], q_data.coord[l]);
      acc_sum[l]  = acc_take ? sum_upd[l] : sum_r[l];
      mean_nxt[l] = clamp_mean(div_quot[l], div_neg[l]);
    end
  end

  assign slot_free = !out_valid_r || out_pop;

  always_comb begin
    state_nxt = state_r;
    sum_nxt   = sum_r;
    tally_nxt = tally_r;
    cnt_nxt   = cnt_r;
    q_pop     = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_RUN: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          sum_nxt   = acc_sum;
          tally_nxt = acc_tally;
          if (q_data.last) begin
            cnt_nxt   = acc_tally;
            sum_nxt   = '0;
            tally_nxt = '0;
            div_start = acc_tally != '0;
            state_nxt = (acc_tally != '0) ? ST_DIV : ST_DONE;
          end
        end
      end
      ST_DIV: begin
        if (!div_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          load_out  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      sum_r       <= '0;
      tally_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      tally_r <= tally_nxt;
      cnt_r   <= cnt_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      kept_r  <= cnt_r;
      empty_r <= cnt_r == '0;
      mean_r  <= (cnt_r == '0) ? '0 : mean_nxt;
    end
  end

  rvpc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_sum),
    .divisor  (acc_tally),
    .busy     (div_busy),
    .quot     (div_quot),
    .neg      (div_neg)
  );

  assign out_valid      = out_valid_r;
  assign out_mean_x     = $signed(mean_r[0]);
  assign out_mean_y     = $signed(mean_r[1]);
  assign out_mean_z     = $signed(mean_r[2]);
  assign out_kept_count = kept_r;
  assign out_box_empty  = empty_r;

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result appeared without a frame close");

  a_div_idle_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> !div_busy)
    else $error("divider busy while back end accumulates");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_box_empty) |-> (out_kept_count == '0))
    else $error("empty box with nonzero count");

  a_no_pop_outside_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_RUN) |-> !q_pop)
    else $error("queue popped during frame close");

endmodule

`default_nettype wire

@@ hdl/roi_valid_point_centroid.sv @@
// Top level of the ROI valid point centroid: config registers, front, queue, back.
//
// Usage: an organized point cloud streams in raster order, one point per
// transaction on the in_ queue port (push/full), as three float32 bit
// patterns plus frame_end on the last point. Points inside the configured
// half-open column/row box with all three coordinates finite are converted
// to signed Q(FRAC_BITS) fixed point and summed. The frame's last point
// produces one result transaction on the out_ queue port (empty/pop): the
// per-axis means truncated toward zero, the kept count and box_empty.
// Throughput: one point per cycle while a frame streams and full is low. Closing
// a frame holds the back end in its divide and done states (bit-serial divider,
// all three axes at once; skipped for an empty box); the 4-entry queue absorbs the
// first points of the next frame, then full rises.
// A result becomes visible once the points queued ahead of it are summed and the
// frame_end point has passed the queue, the divider and the output register.
// A finished result waits in the output register while the next frame
// accumulates; if it is not popped by the next frame close, the back end
// holds and the input side backs up through the queue.
// Reset (rst_n, synchronous) clears position, sums, tally and any pending
// result; image_width returns to 640, the box registers to 0. APB at 4*index.
`timescale 1ns / 1ps
`default_nettype none

module roi_valid_point_centroid
  import rvpc_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input queue port
  input  wire logic                   in_push,
  output logic                        in_full,
  input  wire logic [31:0]            in_coord_x_bits,
  input  wire logic [31:0]            in_coord_y_bits,
  input  wire logic [31:0]            in_coord_z_bits,
  input  wire logic                   in_frame_end,
  // result queue port
  output logic                        out_empty,
  input  wire logic                   out_pop,
  output logic signed [FIX_W-1:0]     out_mean_x,
  output logic signed [FIX_W-1:0]     out_mean_y,
  output logic signed [FIX_W-1:0]     out_mean_z,
  output logic [TALLY_W-1:0]          out_kept_count,
  output logic                        out_box_empty,
  // APB configuration port
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [CFG_ADDR_W-1:0]  paddr,
  input  wire logic [CFG_DATA_W-1:0]  pwdata,
  output logic [CFG_DATA_W-1:0]       prdata,
  output logic                        pready
);

  logic [WIDTH_REG_W-1:0] image_width_r;
  logic [FIRST_REG_W-1:0] box_col_first_r;
  logic [END_REG_W-1:0]   box_col_end_r;
  logic [FIRST_REG_W-1:0] box_row_first_r;
  logic [END_REG_W-1:0]   box_row_end_r;
  logic                   cfg_wr;
  logic [2:0]             cfg_idx;

  logic q_push, q_full, q_pop, q_empty;
  pt_t  q_wdata, q_rdata;
  logic out_valid;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r   <= IMAGE_WIDTH_RESET;
      box_col_first_r <= '0;
      box_col_end_r   <= '0;
      box_row_first_r <= '0;
      box_row_end_r   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_IMAGE_WIDTH:   image_width_r   <= pwdata[WIDTH_REG_W-1:0];
        REG_BOX_COL_FIRST: box_col_first_r <= pwdata[FIRST_REG_W-1:0];
        REG_BOX_COL_END:   box_col_end_r   <= pwdata[END_REG_W-1:0];
        REG_BOX_ROW_FIRST: box_row_first_r <= pwdata[FIRST_REG_W-1:0];
        REG_BOX_ROW_END:   box_row_end_r   <= pwdata[END_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_IMAGE_WIDTH:   prdata = CFG_DATA_W'(image_width_r);
      REG_BOX_COL_FIRST: prdata = CFG_DATA_W'(box_col_first_r);
      REG_BOX_COL_END:   prdata = CFG_DATA_W'(box_col_end_r);
      REG_BOX_ROW_FIRST: prdata = CFG_DATA_W'(box_row_first_r);
      REG_BOX_ROW_END:   prdata = CFG_DATA_W'(box_row_end_r);
      default:           prdata = '0;
    endcase
  end

  // front: position, box test, finiteness, float to fixed
  rvpc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_coord_x_bits (in_coord_x_bits),
    .in_coord_y_bits (in_coord_y_bits),
    .in_coord_z_bits (in_coord_z_bits),
    .in_frame_end    (in_frame_end),
    .image_width     (image_width_r),
    .box_col_first   (box_col_first_r),
    .box_col_end     (box_col_end_r),
    .box_row_first   (box_row_first_r),
    .box_row_end     (box_row_end_r),
    .q_push          (q_push),
    .q_data          (q_wdata),
    .q_full          (q_full)
  );

  // decouples the streaming front from the frame-close stall in the back
  rvpc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // back: sums, tally, mean division, result register
  rvpc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_data         (q_rdata),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_pop        (out_pop),
    .out_mean_x     (out_mean_x),
    .out_mean_y     (out_mean_y),
    .out_mean_z     (out_mean_z),
    .out_kept_count (out_kept_count),
    .out_box_empty  (out_box_empty)
  );

  assign out_empty = !out_valid;

endmodule

`default_nettype wire

@@ tb/roi_valid_point_centroid_test.sv @@
// Self-checking testbench for the ROI valid point centroid block.
`timescale 1ns / 1ps

module roi_valid_point_centroid_test;
  import rvpc_pkg::*;

  // run limits
  localparam int CYCLE_LIMIT   = 500000;
  localparam int DRAIN_CYCLES  = 100;     // lets the back end go quiet after the last result
  localparam int RANDOM_POINTS = 750;
  localparam int PHASE_POINTS  = 100;
  localparam int GAP_PCT       = 38;
  localparam int PROBE_ROWS    = 17;
  localparam int STREAM_POINTS = 300;     // one point per row at width 1
  localparam int MAX_NOTES     = 40;

  // predictor constants
  localparam int     COLS_CAP = DEF_MAX_WIDTH;
  localparam int     ROWS_MOD = DEF_MAX_HEIGHT;
  localparam longint Q_MAX    = 64'sd2147483647;
  localparam longint Q_MIN    = -64'sd2147483648;
  localparam longint SUM_HI   = 64'sd9007199254740991;
  localparam longint SUM_LO   = -SUM_HI - 1;
  localparam logic [7:0] EXP_SPECIAL = 8'hFF;

  // an index the block does not decode; writes to it must change nothing
  localparam logic [2:0] REG_SPARE = 3'd6;

  // register masks
  localparam logic [31:0] MASK_WIDTH = 32'h0000_0FFF;
  localparam logic [31:0] MASK_FIRST = 32'h0000_07FF;
  localparam logic [31:0] MASK_END   = 32'h0000_0FFF;

  typedef struct packed {
    logic [FIX_W-1:0]   mean_x;
    logic [FIX_W-1:0]   mean_y;
    logic [FIX_W-1:0]   mean_z;
    logic [TALLY_W-1:0] kept;
    logic               empty;
  } centroid_t;

  // one row of the directed table; typed rows carry their own expected centroid
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        last;
    logic        typed;
    centroid_t   want;
  } probe_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_push;
  logic                  in_full;
  logic [31:0]           in_coord_x_bits;
  logic [31:0]           in_coord_y_bits;
  logic [31:0]           in_coord_z_bits;
  logic                  in_frame_end;
  logic                  out_empty;
  logic                  out_pop;
  logic signed [FIX_W-1:0] out_mean_x;
  logic signed [FIX_W-1:0] out_mean_y;
  logic signed [FIX_W-1:0] out_mean_z;
  logic [TALLY_W-1:0]    out_kept_count;
  logic                  out_box_empty;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // predictor copy of the registers
  logic [11:0] reg_width;
  logic [10:0] reg_col_first;
  logic [11:0] reg_col_end;
  logic [10:0] reg_row_first;
  logic [11:0] reg_row_end;

  // predictor copy of the frame state
  int unsigned col_pos;
  int unsigned row_pos;
  longint      acc_x;
  longint      acc_y;
  longint      acc_z;
  int unsigned kept_tally;

  centroid_t   pending_centroids[$];

  int          in_gap_pct;
  int          out_gap_pct;
  int          err_count;
  int          points_sent;
  int          frames_sent;
  int          centroids_checked;
  int          settings_tried;
  int          cycle_count;

  roi_valid_point_centroid u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_coord_x_bits (in_coord_x_bits),
    .in_coord_y_bits (in_coord_y_bits),
    .in_coord_z_bits (in_coord_z_bits),
    .in_frame_end    (in_frame_end),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_mean_x      (out_mean_x),
    .out_mean_y      (out_mean_y),
    .out_mean_z      (out_mean_z),
    .out_kept_count  (out_kept_count),
    .out_box_empty   (out_box_empty),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t ns: timeout after %0d cycles, %0d centroids outstanding",
               $time, cycle_count, pending_centroids.size());
      $display("[roi_valid_point_centroid] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // float32 pattern to Q16.16: truncate toward zero, saturate to 32 bits
  function automatic longint q16_of(input logic [31:0] bits);
    int              shift;
    longint unsigned mag;
    longint          val;
    shift = int'(bits[30:23]) - 150 + DEF_FRAC_BITS;
    mag   = {40'd0, 1'b1, bits[22:0]};
    if (bits[30:23] == 8'd0) begin
      val = 0;                       // zero and subnormals
    end else if (shift >= 8) begin
      val = bits[31] ? Q_MIN : Q_MAX;
    end else begin
      if (shift >= 0) begin
        mag = mag << shift;
      end else if (shift <= -25) begin
        mag = 0;
      end else begin
        mag = mag >> (-shift);
      end
      val = bits[31] ? -longint'(mag) : longint'(mag);
    end
    return val;
  endfunction

  function automatic longint clamp_sum(input longint s);
    if (s > SUM_HI) return SUM_HI;
    if (s < SUM_LO) return SUM_LO;
    return s;
  endfunction

  // signed divide truncates toward zero, as the block's divider does
  function automatic logic [FIX_W-1:0] mean_of_sum(input longint s, input int unsigned n);
    longint m;
    m = s / longint'(n);
    if (m > Q_MAX) m = Q_MAX;
    if (m < Q_MIN) m = Q_MIN;
    return m[FIX_W-1:0];
  endfunction

  function automatic centroid_t centroid(input logic [31:0] mx, my, mz,
                                         input int unsigned kept, input logic empty);
    centroid_t c;
    c.mean_x = mx;
    c.mean_y = my;
    c.mean_z = mz;
    c.kept   = kept[TALLY_W-1:0];
    c.empty  = empty;
    return c;
  endfunction

  function automatic probe_row_t probe(input logic [31:0] x, y, z, input logic last,
                                       input logic typed, input centroid_t want);
    probe_row_t r;
    r.x     = x;
    r.y     = y;
    r.z     = z;
    r.last  = last;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  task automatic clear_frame_state();
    col_pos    = 0;
    row_pos    = 0;
    acc_x      = 0;
    acc_y      = 0;
    acc_z      = 0;
    kept_tally = 0;
  endtask

  // advance the model by one accepted point; returns the centroid on frame end
  task automatic predict_point(input logic [31:0] x, y, z, input logic last,
                               output logic has_res, output centroid_t res);
    int unsigned span;
    logic        in_box;
    logic        finite;
    span   = (reg_width == 0) ? 1 : ((reg_width > COLS_CAP) ? COLS_CAP : reg_width);
    in_box = col_pos >= reg_col_first && col_pos < reg_col_end &&
             row_pos >= reg_row_first && row_pos < reg_row_end;
    finite = x[30:23] != EXP_SPECIAL && y[30:23] != EXP_SPECIAL &&
             z[30:23] != EXP_SPECIAL;
    if (in_box && finite && kept_tally < TALLY_MAX) begin
      acc_x      = clamp_sum(acc_x + q16_of(x));
      acc_y      = clamp_sum(acc_y + q16_of(y));
      acc_z      = clamp_sum(acc_z + q16_of(z));
      kept_tally = kept_tally + 1;
    end
    // raster position moves on for every point, dropped or not
    if (col_pos + 1 >= span) begin
      col_pos = 0;
      row_pos = (row_pos + 1) % ROWS_MOD;
    end else begin
      col_pos = col_pos + 1;
    end
    has_res = last;
    res     = '0;
    if (last) begin
      if (kept_tally == 0) begin
        res.empty = 1'b1;
      end else begin
        res = centroid(mean_of_sum(acc_x, kept_tally), mean_of_sum(acc_y, kept_tally),
                       mean_of_sum(acc_z, kept_tally), kept_tally, 1'b0);
      end
      clear_frame_state();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random pop, compare each popped transaction with the oldest
  // expectation
  // ---------------------------------------------------------------------------

  task automatic note_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      err_count++;
      if (err_count <= MAX_NOTES)
        $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  task automatic check_centroid();
    centroid_t want;
    if (pending_centroids.size() == 0) begin
      err_count++;
      if (err_count <= MAX_NOTES)
        $display("%0t ns: unexpected result, expected none actual mean (%h %h %h) count %0d",
                 $time, out_mean_x, out_mean_y, out_mean_z, out_kept_count);
    end else begin
      want = pending_centroids.pop_front();
      centroids_checked++;
      note_field("mean_x", want.mean_x, out_mean_x);
      note_field("mean_y", want.mean_y, out_mean_y);
      note_field("mean_z", want.mean_z, out_mean_z);
      note_field("kept_count", 32'(want.kept), 32'(out_kept_count));
      note_field("box_empty", 32'(want.empty), 32'(out_box_empty));
    end
  endtask

  initial begin
    out_pop = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_pop && out_empty === 1'b0)
        check_centroid();
      @(negedge clk);
      out_pop = (rst_n === 1'b1) && ($urandom_range(99) >= out_gap_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers (all entered and left at a falling edge)
  // ---------------------------------------------------------------------------

  // one APB transaction: setup, access, done at the edge with pready high
  task automatic cfg_access(input logic [2:0] idx, input logic wr, input logic [31:0] data);
    logic [31:0] want;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = CFG_ADDR_W'({idx, 2'b00});
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (wr) begin
      case (idx)
        REG_IMAGE_WIDTH:   reg_width     = data[11:0];
        REG_BOX_COL_FIRST: reg_col_first = data[10:0];
        REG_BOX_COL_END:   reg_col_end   = data[11:0];
        REG_BOX_ROW_FIRST: reg_row_first = data[10:0];
        REG_BOX_ROW_END:   reg_row_end   = data[11:0];
        default: ;                   // undecoded index: no effect
      endcase
    end else begin
      case (idx)
        REG_IMAGE_WIDTH:   want = 32'(reg_width);
        REG_BOX_COL_FIRST: want = 32'(reg_col_first);
        REG_BOX_COL_END:   want = 32'(reg_col_end);
        REG_BOX_ROW_FIRST: want = 32'(reg_row_first);
        REG_BOX_ROW_END:   want = 32'(reg_row_end);
        default:           want = prdata;
      endcase
      note_field("prdata", want, prdata);
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_registers();
    cfg_access(REG_IMAGE_WIDTH, 1'b0, '0);
    cfg_access(REG_BOX_COL_FIRST, 1'b0, '0);
    cfg_access(REG_BOX_COL_END, 1'b0, '0);
    cfg_access(REG_BOX_ROW_FIRST, 1'b0, '0);
    cfg_access(REG_BOX_ROW_END, 1'b0, '0);
  endtask

  // program all registers; upper bits carry junk that the block must mask off
  task automatic apply_settings(input int unsigned w, cf, ce, rf, re);
    cfg_access(REG_IMAGE_WIDTH, 1'b1, ($urandom() & ~MASK_WIDTH) | (w & MASK_WIDTH));
    cfg_access(REG_BOX_COL_FIRST, 1'b1, ($urandom() & ~MASK_FIRST) | (cf & MASK_FIRST));
    cfg_access(REG_BOX_COL_END, 1'b1, ($urandom() & ~MASK_END) | (ce & MASK_END));
    cfg_access(REG_BOX_ROW_FIRST, 1'b1, ($urandom() & ~MASK_FIRST) | (rf & MASK_FIRST));
    cfg_access(REG_BOX_ROW_END, 1'b1, ($urandom() & ~MASK_END) | (re & MASK_END));
    cfg_access(REG_SPARE, 1'b1, $urandom());
    check_registers();
    settings_tried++;
  endtask

  // wait until every centroid is back, then let the back end go quiet
  task automatic settle();
    in_push = 1'b0;
    while (pending_centroids.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // push one point; push stays high into the next call unless that call idles
  task automatic send_point(input logic [31:0] x, y, z, input logic last,
                            input logic typed, input centroid_t typed_res);
    logic      taken;
    logic      has_res;
    centroid_t res;
    while ($urandom_range(99) < in_gap_pct) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_push         = 1'b1;
    in_coord_x_bits = x;
    in_coord_y_bits = y;
    in_coord_z_bits = z;
    in_frame_end    = last;
    taken           = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = (in_full === 1'b0);
      @(negedge clk);
    end
    points_sent++;
    predict_point(x, y, z, last, has_res, res);
    if (last) frames_sent++;
    if (has_res)
      pending_centroids.insert(pending_centroids.size(), typed ? typed_res : res);
  endtask

  // clean frames keep values in the useful Q16.16 range; noisy ones mix in
  // saturating, tiny, subnormal, NaN, infinite and raw patterns
  function automatic logic [31:0] pick_coord(input logic noisy);
    int unsigned roll;
    logic [7:0]  ex;
    roll = noisy ? $urandom_range(99) : 0;
    if (roll < 55)      ex = 8'($urandom_range(141, 112));
    else if (roll < 68) ex = 8'($urandom_range(254, 142));
    else if (roll < 78) ex = 8'($urandom_range(111, 0));
    else if (roll < 88) ex = EXP_SPECIAL;
    else return $urandom();
    return {1'($urandom_range(1)), ex, 23'($urandom())};
  endfunction

  task automatic send_frame(input int unsigned len, input logic noisy);
    int unsigned i;
    for (i = 0; i < len; i++)
      send_point(pick_coord(noisy), pick_coord(noisy), pick_coord(noisy),
                 i == len - 1, 1'b0, '0);
  endtask

  task automatic run_frames(input int unsigned budget);
    int unsigned start;
    int unsigned len;
    start = points_sent;
    while (points_sent - start < budget) begin
      len = ($urandom_range(9) == 0) ? 1 : $urandom_range(60, 1);
      send_frame(len, $urandom_range(3) == 0);
    end
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    probe_row_t  probe_rows [PROBE_ROWS];
    int unsigned i;
    int unsigned w, cf, ce, rf, re;
    int unsigned random_start;

    rst_n           = 1'b0;
    in_push         = 1'b0;
    in_coord_x_bits = '0;
    in_coord_y_bits = '0;
    in_coord_z_bits = '0;
    in_frame_end    = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_gap_pct      = GAP_PCT;
    out_gap_pct     = GAP_PCT;
    err_count       = 0;
    points_sent     = 0;
    frames_sent     = 0;
    centroids_checked = 0;
    settings_tried  = 0;
    cycle_count     = 0;

    reg_width     = IMAGE_WIDTH_RESET;
    reg_col_first = '0;
    reg_col_end   = '0;
    reg_row_first = '0;
    reg_row_end   = '0;
    clear_frame_state();

    // row 0 runs with the reset box (end 0), so it can only be empty
    probe_rows[0]  = probe(32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, 1'b1, 1'b1,
                           centroid('0, '0, '0, 0, 1'b1));
    // single point frames: the mean is the converted point itself
    probe_rows[1]  = probe(32'h3F80_0000, 32'hBFC0_0000, 32'h0000_0000, 1'b1, 1'b1,
                           centroid(32'h0001_0000, 32'hFFFE_8000, '0, 1, 1'b0));
    probe_rows[2]  = probe(32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h4700_0000, 1'b1, 1'b1,
                           centroid(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1'b0));
    // largest magnitude below saturation, and exactly -32768.0
    probe_rows[3]  = probe(32'h46FF_FFFF, 32'hC6FF_FFFF, 32'hC700_0000, 1'b1, 1'b1,
                           centroid(32'h7FFF_FF80, 32'h8000_0080, 32'h8000_0000, 1, 1'b0));
    // subnormals and values below one LSB convert to zero but still count
    probe_rows[4]  = probe(32'h007F_FFFF, 32'h8000_0001, 32'h3700_0000, 1'b1, 1'b1,
                           centroid('0, '0, '0, 1, 1'b0));
    probe_rows[5]  = probe(32'h3780_0000, 32'hB780_0000, 32'h8000_0000, 1'b1, 1'b1,
                           centroid(32'h0000_0001, 32'hFFFF_FFFF, '0, 1, 1'b0));
    // NaN or infinity on any axis drops the point
    probe_rows[6]  = probe(32'h7FC0_0000, 32'h3F80_0000, 32'h3F80_0000, 1'b1, 1'b1,
                           centroid('0, '0, '0, 0, 1'b1));
    probe_rows[7]  = probe(32'h3F80_0000, 32'h7F80_0000, 32'h3F80_0000, 1'b1, 1'b1,
                           centroid('0, '0, '0, 0, 1'b1));
    probe_rows[8]  = probe(32'h3F80_0000, 32'h3F80_0000, 32'hFF80_0000, 1'b1, 1'b1,
                           centroid('0, '0, '0, 0, 1'b1));
    // multi point frames go through the predictor
    probe_rows[9]  = probe(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, '0);
    probe_rows[10] = probe(32'h3F80_0000, 32'h4000_0000, 32'hC040_0000, 1'b0, 1'b0, '0);
    probe_rows[11] = probe(32'h4040_0000, 32'hC080_0000, 32'h3FC0_0000, 1'b1, 1'b0, '0);
    // mean of -1 LSB over three points truncates toward zero
    probe_rows[12] = probe(32'h3780_0000, 32'hB800_0000, 32'h0000_0000, 1'b0, 1'b0, '0);
    probe_rows[13] = probe(32'h0000_0000, 32'h3780_0000, 32'hB780_0000, 1'b0, 1'b0, '0);
    probe_rows[14] = probe(32'h0000_0000, 32'h0000_0000, 32'h3780_0000, 1'b1, 1'b0, '0);
    // alternating and mixed bit patterns on the inputs
    probe_rows[15] = probe(32'hAAAA_AAAA, 32'h5555_5555, 32'h2AAA_AAAA, 1'b0, 1'b0, '0);
    probe_rows[16] = probe(32'hD555_5555, 32'h1234_5678, 32'hEDCB_A987, 1'b1, 1'b0, '0);

    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // registers must come out of reset at their documented values
    check_registers();

    // directed table: row 0 under reset settings, the rest with a full box
    send_point(probe_rows[0].x, probe_rows[0].y, probe_rows[0].z, probe_rows[0].last,
               probe_rows[0].typed, probe_rows[0].want);
    settle();
    apply_settings(4, 0, 2048, 0, 2048);
    for (i = 1; i < PROBE_ROWS; i++)
      send_point(probe_rows[i].x, probe_rows[i].y, probe_rows[i].z, probe_rows[i].last,
                 probe_rows[i].typed, probe_rows[i].want);
    settle();

    // fixed settings covering the register extremes
    apply_settings(5, 1, 4, 2, 9);              // small interior box
    run_frames(PHASE_POINTS);
    apply_settings(0, 0, 2048, 3, 10);          // width 0 behaves as 1
    run_frames(PHASE_POINTS);
    apply_settings(4095, 2047, 2048, 0, 2048);  // width clamps to 2048, last column only
    run_frames(PHASE_POINTS);
    apply_settings(2048, 0, 2048, 0, 2048);     // whole frame inside
    run_frames(PHASE_POINTS);
    apply_settings(3, 6, 2, 0, 5);              // column end below first: always empty
    run_frames(PHASE_POINTS);

    // one long frame at full rate on both sides, one point per row;
    // rows from 100 on are kept
    in_gap_pct  = 0;
    out_gap_pct = 0;
    apply_settings(1, 0, 1, 100, 2048);
    send_frame(STREAM_POINTS, 1'b0);
    settle();
    in_gap_pct  = GAP_PCT;
    out_gap_pct = GAP_PCT;

    // random settings, mostly narrow rasters so frames span many rows
    random_start = points_sent;
    while (points_sent - random_start < RANDOM_POINTS) begin
      case ($urandom_range(7))
        0:       w = 0;
        1:       w = 2048;
        2:       w = $urandom_range(4095, 2049);
        default: w = $urandom_range(12, 1);
      endcase
      cf = ($urandom_range(15) == 0) ? 2047 : $urandom_range(6, 0);
      ce = ($urandom_range(5) == 0) ? 2048 : $urandom_range(14, 0);
      rf = ($urandom_range(15) == 0) ? 2047 : $urandom_range(8, 0);
      re = ($urandom_range(5) == 0) ? 2048 : $urandom_range(18, 0);
      apply_settings(w, cf, ce, rf, re);
      run_frames(PHASE_POINTS);
    end

    settle();
    $display("summary: %0d points in %0d frames over %0d register settings",
             points_sent, frames_sent, settings_tried);
    $display("summary: %0d centroids compared, %0d mismatches", centroids_checked, err_count);
    if (err_count == 0 && pending_centroids.size() == 0) begin
      $display("[roi_valid_point_centroid] OK");
    end else begin
      $display("[roi_valid_point_centroid] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/rvpc_pkg.sv
hdl/rvpc_queue.sv
hdl/rvpc_front.sv
hdl/rvpc_div.sv
hdl/rvpc_back.sv
hdl/roi_valid_point_centroid.sv
tb/roi_valid_point_centroid_test.sv
